### rtl/kdbc_pkg.sv
// kdbc_pkg: shared types and constants of the dma byte counter table
// no dependencies; used by kdbc_cell and keyed_dma_byte_counter_table_unit
`timescale 1ns / 1ps
`default_nettype none

package kdbc_pkg;

  localparam int unsigned ENTRIES_DEF = 32;
  localparam int unsigned SUM_W       = 64;
  localparam int unsigned KEY_W       = 8;
  localparam int unsigned IDX_W       = 5;
  localparam int unsigned STAT_W      = 3;
  localparam int unsigned USED_W      = 6;

  localparam logic [STAT_W-1:0] ST_IGNORED = 3'd0;
  localparam logic [STAT_W-1:0] ST_HIT     = 3'd1;
  localparam logic [STAT_W-1:0] ST_NEW     = 3'd2;
  localparam logic [STAT_W-1:0] ST_FULL    = 3'd3;
  localparam logic [STAT_W-1:0] ST_READ_OK = 3'd4;
  localparam logic [STAT_W-1:0] ST_BAD_IDX = 3'd5;

  // request held in the table while it is worked on
  typedef struct packed {
    logic             rd;
    logic [KEY_W-1:0] dev;
    logic [KEY_W-1:0] chan;
    logic [IDX_W-1:0] idx;
  } probe_t;

  // update broadcast to all cells
  typedef struct packed {
    logic             we_hit;
    logic             we_new;
    logic [SUM_W-1:0] rsum;
    logic [SUM_W-1:0] wsum;
  } cmd_t;

  // collected entry passed from cell to cell
  typedef struct packed {
    logic             hit;
    logic [IDX_W-1:0] slot;
    logic [KEY_W-1:0] dev;
    logic [KEY_W-1:0] chan;
    logic [SUM_W-1:0] rsum;
    logic [SUM_W-1:0] wsum;
  } link_t;

endpackage

`default_nettype wire

### rtl/keyed_dma_byte_counter_table_unit.sv
// keyed_dma_byte_counter_table_unit: per (device, channel) dma byte accounting table
// depends on kdbc_pkg and kdbc_cell (one cell per entry, chained)
//
//   channel  | dir | payload                                   | request taken when
//   s_axis   | in  | tuser kind, tdata key/flag/bytes/index     | tvalid & tready
//   m_axis   | out | tuser status, tdata entry and totals       | tvalid & tready
//   cfg      | in  | data = enable                              | valid & ready
//
// each request is captured, then matched and updated along the cell chain
// the result sits in an output register; the next request is taken meanwhile
// a full output register holds the update step until it drains
// reset clears all sums, the fill count, the totals and enable; no clearing pass
`timescale 1ns / 1ps
`default_nettype none

module keyed_dma_byte_counter_table_unit #(
  parameter int unsigned ENTRIES = kdbc_pkg::ENTRIES_DEF
) (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         s_axis_tvalid_i,
  output logic              s_axis_tready_o,
  input  wire logic [87:0]  s_axis_tdata_i,  // device 8, channel 8, write 1, bytes 64, index 5
  input  wire logic [0:0]   s_axis_tuser_i,  // kind
  output logic              m_axis_tvalid_o,
  input  wire logic         m_axis_tready_i,
  output logic [351:0]      m_axis_tdata_o,  // slot 5, device 8, channel 8, read 64, write 64,
                                             // total read 64, total write 64, total 64, used 6
  output logic [2:0]        m_axis_tuser_o,  // status
  input  wire logic         cfg_valid_i,
  output logic              cfg_ready_o,
  input  wire logic         cfg_data_i
);

  localparam int unsigned CW = $clog2(ENTRIES + 1);
  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_EXEC = 1'b1;

  logic state_q, state_d;
  logic en_q;
  kdbc_pkg::probe_t probe_q;
  logic wr_q;
  logic [kdbc_pkg::SUM_W-1:0] bytes_q;
  logic [CW-1:0] used_q, used_d;
  logic [kdbc_pkg::SUM_W-1:0] gr_q, gw_q, ga_q, gr_d, gw_d, ga_d;
  logic m_valid_q;
  logic [351:0] m_data_q, m_data_d;
  logic [2:0] m_user_q, st;
  kdbc_pkg::cmd_t cmd;
  kdbc_pkg::link_t link [ENTRIES+1];
  kdbc_pkg::link_t sel;
  logic [ENTRIES-1:0] match;
  logic go, upd, accept;
  logic [kdbc_pkg::IDX_W-1:0] o_slot;
  logic [kdbc_pkg::KEY_W-1:0] o_dev, o_chan;
  logic [kdbc_pkg::SUM_W-1:0] o_rb, o_wb;

  assign link[0] = '0;

  for (genvar g = 0; g < ENTRIES; g++) begin : g_cell
    kdbc_cell #(.CW(CW), .POS(g)) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .probe_i (probe_q),
      .used_i  (used_q),
      .cmd_i   (cmd),
      .link_i  (link[g]),
      .link_o  (link[g+1]),
      .match_o (match[g])
    );
  end

  assign sel             = link[ENTRIES];
  assign s_axis_tready_o = (state_q == ST_IDLE);
  assign cfg_ready_o     = 1'b1;
  assign accept          = s_axis_tvalid_i && s_axis_tready_o;
  assign go              = (state_q == ST_EXEC) && (!m_valid_q || m_axis_tready_i);
  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = m_data_q;
  assign m_axis_tuser_o  = m_user_q;

  always_comb begin
    priority if (!en_q) begin
      st = kdbc_pkg::ST_IGNORED;
    end else if (probe_q.rd) begin
      st = (32'(probe_q.idx) < 32'(used_q)) ? kdbc_pkg::ST_READ_OK : kdbc_pkg::ST_BAD_IDX;
    end else if (bytes_q == '0) begin
      st = kdbc_pkg::ST_IGNORED;
    end else if (sel.hit) begin
      st = kdbc_pkg::ST_HIT;
    end else if (used_q == CW'(ENTRIES)) begin
      st = kdbc_pkg::ST_FULL;
    end else begin
      st = kdbc_pkg::ST_NEW;
    end
    upd = (st == kdbc_pkg::ST_HIT) || (st == kdbc_pkg::ST_NEW);

    cmd.we_hit = go && (st == kdbc_pkg::ST_HIT);
    cmd.we_new = go && (st == kdbc_pkg::ST_NEW);
    cmd.rsum   = wr_q ? sel.rsum : sel.rsum + bytes_q;
    cmd.wsum   = wr_q ? sel.wsum + bytes_q : sel.wsum;

    gr_d   = (upd && !wr_q) ? gr_q + bytes_q : gr_q;
    gw_d   = (upd && wr_q) ? gw_q + bytes_q : gw_q;
    ga_d   = upd ? ga_q + bytes_q : ga_q;
    used_d = (st == kdbc_pkg::ST_NEW) ? used_q + CW'(1) : used_q;

    o_slot = '0;
    o_dev  = '0;
    o_chan = '0;
    o_rb   = '0;
    o_wb   = '0;
    unique case (st)
      kdbc_pkg::ST_HIT: begin
        o_slot = sel.slot;
        o_dev  = sel.dev;
        o_chan = sel.chan;
        o_rb   = cmd.rsum;
        o_wb   = cmd.wsum;
      end
      kdbc_pkg::ST_NEW: begin
        o_slot = kdbc_pkg::IDX_W'(used_q);
        o_dev  = probe_q.dev;
        o_chan = probe_q.chan;
        o_rb   = cmd.rsum;
        o_wb   = cmd.wsum;
      end
      kdbc_pkg::ST_READ_OK: begin
        o_slot = sel.slot;
        o_dev  = sel.dev;
        o_chan = sel.chan;
        o_rb   = sel.rsum;
        o_wb   = sel.wsum;
      end
      kdbc_pkg::ST_BAD_IDX: begin
        o_slot = probe_q.idx;
      end
      default: begin
      end
    endcase

    m_data_d = {5'd0, kdbc_pkg::USED_W'(used_d), ga_d, gw_d, gr_d, o_wb, o_rb,
                o_chan, o_dev, o_slot};

    state_d = state_q;
    if (accept) begin
      state_d = ST_EXEC;
    end else if (go) begin
      state_d = ST_IDLE;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      en_q      <= 1'b0;
      used_q    <= '0;
      gr_q      <= '0;
      gw_q      <= '0;
      ga_q      <= '0;
      m_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_valid_i) begin
        en_q <= cfg_data_i;
      end
      if (go) begin
        used_q    <= used_d;
        gr_q      <= gr_d;
        gw_q      <= gw_d;
        ga_q      <= ga_d;
        m_valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        m_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      probe_q.rd   <= s_axis_tuser_i[0];
      probe_q.dev  <= s_axis_tdata_i[7:0];
      probe_q.chan <= s_axis_tdata_i[15:8];
      wr_q         <= s_axis_tdata_i[16];
      bytes_q      <= s_axis_tdata_i[80:17];
      probe_q.idx  <= s_axis_tdata_i[85:81];
    end
    if (go) begin
      m_data_q <= m_data_d;
      m_user_q <= st;
    end
  end

  a_used_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    used_q <= CW'(ENTRIES))
    else $error("fill count beyond table size");

  a_key_unique: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_EXEC) |-> $onehot0(match))
    else $error("key stored in more than one entry");

  a_result_loaded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    go |=> m_valid_q && (state_q == ST_IDLE))
    else $error("result not loaded after update step");

  a_used_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !cmd.we_new |=> $stable(used_q))
    else $error("fill count moved without a new entry");

  a_totals_sum: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ga_q == gr_q + gw_q)
    else $error("grand total out of step with read and write totals");

endmodule

`default_nettype wire

### rtl/kdbc_cell.sv
// kdbc_cell: one table entry with key match and sum storage
// depends on kdbc_pkg; chained by keyed_dma_byte_counter_table_unit
`timescale 1ns / 1ps
`default_nettype none

module kdbc_cell #(
  parameter int unsigned CW  = 6,
  parameter int unsigned POS = 0
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire kdbc_pkg::probe_t probe_i,
  input  wire logic [CW-1:0]   used_i,
  input  wire kdbc_pkg::cmd_t  cmd_i,
  input  wire kdbc_pkg::link_t link_i,
  output kdbc_pkg::link_t      link_o,
  output logic                 match_o
);

  logic [kdbc_pkg::KEY_W-1:0] dev_q, chan_q;
  logic [kdbc_pkg::SUM_W-1:0] rsum_q, wsum_q;
  logic filled, at_used, pick, we;

  always_comb begin
    filled  = CW'(POS) < used_i;
    at_used = CW'(POS) == used_i;
    match_o = filled && !probe_i.rd && (dev_q == probe_i.dev) && (chan_q == probe_i.chan);
    pick    = match_o || (probe_i.rd && filled && (32'(probe_i.idx) == 32'(POS)));
    we      = (cmd_i.we_hit && match_o) || (cmd_i.we_new && at_used);
    link_o  = link_i;
    link_o.hit = link_i.hit | match_o;
    if (pick) begin
      link_o.slot = link_i.slot | kdbc_pkg::IDX_W'(POS);
      link_o.dev  = link_i.dev  | dev_q;
      link_o.chan = link_i.chan | chan_q;
      link_o.rsum = link_i.rsum | rsum_q;
      link_o.wsum = link_i.wsum | wsum_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rsum_q <= '0;
      wsum_q <= '0;
    end else if (we) begin
      rsum_q <= cmd_i.rsum;
      wsum_q <= cmd_i.wsum;
    end
  end

  // key store, undefined until filled
  always_ff @(posedge clk_i) begin
    if (cmd_i.we_new && at_used) begin
      dev_q  <= probe_i.dev;
      chan_q <= probe_i.chan;
    end
  end

endmodule

`default_nettype wire
